[hdl/dgsp_pkg.sv]
`timescale 1ns / 1ps

package dgsp_pkg;

    // Widths of the item fields.
    localparam int VTX_W    = 4;
    localparam int WGT_IN_W = 16;
    localparam int DIST_W   = 20;
    localparam int CNT_W    = 5;

    localparam logic [DIST_W-1:0] DIST_MAX       = 20'hFFFFF;
    localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 5'd16;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_EDGE  = 2'd1;
    localparam logic [1:0] REQ_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [VTX_W-1:0]    from_vertex;
        logic [VTX_W-1:0]    to_vertex;
        logic [WGT_IN_W-1:0] edge_weight;
        logic [VTX_W-1:0]    source_vertex;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0]  vertex;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic              source_error;
        logic              last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_PICK,
        S_SETTLE,
        S_RELAX,
        S_RELAX_END,
        S_OUT_RD,
        S_OUT_WR,
        S_ERR
    } t_state;

endpackage

[hdl/dense_graph_shortest_path.sv]
`timescale 1ns / 1ps
// Edge write: accepted while idle, without stalling the input. A clear stalls the input
// while it sweeps every entry of the edge RAM. A run offers one result per vertex in use,
// in vertex order with the last one flagged; each result passes through S_OUT_RD and
// S_OUT_WR and waits there while the output stalls. A source out of range offers a single
// error result from S_ERR. Reset is synchronous, active low; after reset a sweep over
// every edge entry marks every edge absent before the first item is accepted.

module dense_graph_shortest_path #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dgsp_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  dgsp_pkg::t_in_item        i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output dgsp_pkg::t_out_item       o_out_item
);

    import dgsp_pkg::*;

    // The adjacency matrix lives in one RAM addressed by {from, to}. Each entry holds a
    // present bit above the weight. The best-distance scratch lives in a second RAM with
    // one entry per vertex; the known and settled flags are flop vectors, so a distance
    // entry is only trusted once its known flag is set and needs no initialization.
    localparam int VW     = $clog2(MAX_NODES);
    localparam int NW     = $clog2(MAX_NODES + 1);
    localparam int EAW    = 2 * VW;
    localparam int EDEPTH = 1 << EAW;
    localparam int EW     = WEIGHT_BITS + 1;
    localparam int WXW    = (WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_node_count;
    logic [EAW-1:0]       r_clr_addr;
    logic [VW-1:0]        r_idx;
    logic [VW-1:0]        r_pidx;
    logic                 r_pend;
    logic [VTX_W-1:0]     r_src;
    logic [MAX_NODES-1:0] r_known;
    logic [MAX_NODES-1:0] r_settled;
    logic                 r_found;
    logic [VW-1:0]        r_u;
    logic [DIST_W-1:0]    r_best;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic [NW-1:0]        w_n;
    logic [VW-1:0]        w_last_idx;
    logic                 w_idx_last;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_edge_ok;
    logic                 w_src_ok;

    logic                 e_we;
    logic [EAW-1:0]       e_waddr;
    logic [EW-1:0]        e_wdata;
    logic [EAW-1:0]       e_raddr;
    logic [EW-1:0]        e_rdata;

    logic                 d_we;
    logic [VW-1:0]        d_waddr;
    logic [DIST_W-1:0]    d_wdata;
    logic [VW-1:0]        d_raddr;
    logic [DIST_W-1:0]    d_rdata;

    logic [WXW-1:0]       w_wext;
    logic [DIST_W-1:0]    w_wclip;
    logic [DIST_W:0]      w_sum;
    logic [DIST_W-1:0]    w_cand;
    logic                 w_relax_upd;
    logic                 w_scan_upd;
    logic                 w_out_load;
    t_out_item            w_out_item;

    // The vertex count in use is the register clamped to 1..MAX_NODES.
    always_comb begin
        if (r_node_count == '0) begin
            w_n = NW'(1);
        end else if (32'(r_node_count) > MAX_NODES) begin
            w_n = NW'(MAX_NODES);
        end else begin
            w_n = NW'(r_node_count);
        end
    end

    assign w_last_idx = VW'(w_n - NW'(1));
    assign w_idx_last = (r_idx == w_last_idx);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_edge_ok  = (i_in_item.from_vertex < w_n) && (i_in_item.to_vertex < w_n);
    assign w_src_ok   = (i_in_item.source_vertex < w_n);

    // Relaxation datapath: both RAMs register their read data, which line up with r_pidx,
    // the index issued in the cycle before. The weight is clipped to the distance range, added to the
    // distance of the vertex being settled, and the sum saturates at the top code.
    assign w_wext  = WXW'(e_rdata[WEIGHT_BITS-1:0]);
    assign w_wclip = (w_wext > WXW'(DIST_MAX)) ? DIST_MAX : DIST_W'(w_wext);
    assign w_sum   = {1'b0, r_best} + {1'b0, w_wclip};
    assign w_cand  = w_sum[DIST_W] ? DIST_MAX : w_sum[DIST_W-1:0];

    assign w_relax_upd = r_pend && ((r_state == S_RELAX) || (r_state == S_RELAX_END))
                         && e_rdata[EW-1] && !r_settled[r_pidx]
                         && (!r_known[r_pidx] || (w_cand < d_rdata));

    // Minimum search: a strict compare keeps the lowest index among equal distances.
    assign w_scan_upd = r_pend && ((r_state == S_SCAN) || (r_state == S_PICK))
                        && !r_settled[r_pidx] && r_known[r_pidx]
                        && (!r_found || (d_rdata < r_best));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_item.req_type)
                        REQ_CLEAR: n_state = S_CLEAR;
                        REQ_RUN:   n_state = w_src_ok ? S_INIT : S_ERR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INIT:      n_state = S_SCAN;
            S_SCAN: begin
                if (w_idx_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK:      n_state = S_SETTLE;
            S_SETTLE:    n_state = r_found ? S_RELAX : S_OUT_RD;
            S_RELAX: begin
                if (w_idx_last) begin
                    n_state = S_RELAX_END;
                end
            end
            S_RELAX_END: n_state = S_SCAN;
            S_OUT_RD:    n_state = S_OUT_WR;
            S_OUT_WR: begin
                if (w_out_free) begin
                    n_state = w_idx_last ? S_IDLE : S_OUT_RD;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath controls decoded from the state.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        e_we       = 1'b0;
        e_waddr    = '0;
        e_wdata    = '0;
        e_raddr    = '0;
        d_we       = 1'b0;
        d_waddr    = '0;
        d_wdata    = '0;
        d_raddr    = '0;
        w_out_load = 1'b0;
        w_out_item = '0;
        unique case (r_state)
            S_CLEAR: begin
                e_we    = 1'b1;
                e_waddr = r_clr_addr;
            end
            S_IDLE: begin
                if (w_in_acc && (i_in_item.req_type == REQ_EDGE) && w_edge_ok) begin
                    e_we    = 1'b1;
                    e_waddr = {VW'(i_in_item.from_vertex), VW'(i_in_item.to_vertex)};
                    e_wdata = {1'b1, WEIGHT_BITS'(i_in_item.edge_weight)};
                end
            end
            S_INIT: begin
                d_we    = 1'b1;
                d_waddr = VW'(r_src);
            end
            S_SCAN: begin
                d_raddr = r_idx;
            end
            S_RELAX: begin
                e_raddr = {r_u, r_idx};
                d_raddr = r_idx;
            end
            S_OUT_RD: begin
                d_raddr = r_idx;
            end
            S_OUT_WR: begin
                d_raddr = r_idx;
                if (w_out_free) begin
                    w_out_load              = 1'b1;
                    w_out_item.vertex       = VTX_W'(r_idx);
                    w_out_item.distance     = r_known[r_idx] ? d_rdata : '0;
                    w_out_item.reachable    = r_known[r_idx];
                    w_out_item.source_error = 1'b0;
                    w_out_item.last         = w_idx_last;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    w_out_load              = 1'b1;
                    w_out_item.vertex       = r_src;
                    w_out_item.source_error = 1'b1;
                    w_out_item.last         = 1'b1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        if (w_relax_upd) begin
            d_we    = 1'b1;
            d_waddr = r_pidx;
            d_wdata = w_cand;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_node_count <= NODE_COUNT_RST;
            r_clr_addr   <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            // The sweep address wraps back to zero as it finishes.
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + EAW'(1);
            end
            r_pend <= (r_state == S_SCAN) || (r_state == S_RELAX);
            if ((r_state == S_INIT) || (r_state == S_RELAX_END)) begin
                r_found <= 1'b0;
            end else if (w_scan_upd) begin
                r_found <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Search scratch and payload registers.
    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
        unique case (r_state)
            S_INIT, S_SETTLE, S_RELAX_END: r_idx <= '0;
            S_SCAN, S_RELAX:               r_idx <= r_idx + VW'(1);
            S_OUT_WR: begin
                if (w_out_free) begin
                    r_idx <= r_idx + VW'(1);
                end
            end
            default: r_idx <= r_idx;
        endcase
        if (w_in_acc) begin
            r_src <= i_in_item.source_vertex;
        end
        if (r_state == S_INIT) begin
            r_known   <= MAX_NODES'(1) << r_src;
            r_settled <= '0;
        end else begin
            if ((r_state == S_SETTLE) && r_found) begin
                r_settled[r_u] <= 1'b1;
            end
            if (w_relax_upd) begin
                r_known[r_pidx] <= 1'b1;
            end
        end
        if (w_scan_upd) begin
            r_u    <= r_pidx;
            r_best <= d_rdata;
        end
        if (w_out_load) begin
            r_out <= w_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    dgsp_ram #(
        .WIDTH (EW),
        .DEPTH (EDEPTH)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    dgsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (1 << VW)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    // An error result always closes its run.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.source_error) |-> r_out.last)
        else $error("error result without last");

    // Unreachable vertices report a zero distance.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.reachable) |-> (r_out.distance == '0))
        else $error("unreachable vertex with nonzero distance");

    // The picked vertex is marked settled before its edges are relaxed.
    a_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SETTLE) && r_found) |=> r_settled[$past(r_u)])
        else $error("picked vertex not settled");

    // A candidate is only found during the minimum search.
    a_found_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> ((r_state == S_SCAN) || (r_state == S_PICK)
                            || (r_state == S_SETTLE)))
        else $error("candidate found outside the search");

endmodule

[hdl/dgsp_ram.sv]
`timescale 1ns / 1ps

module dgsp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
